// File: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers that compile away in synthesis builds.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Clocked assertion, disabled while the active-low reset is asserted.
`define BTOT_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("box/triangle overlap assertion failed");
// Clocked assertion that is checked during reset as well.
`define BTOT_ASSERT_NR(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("box/triangle overlap assertion failed");
`else
`define BTOT_ASSERT(lbl, clk, rst_n, prop)
`define BTOT_ASSERT_NR(lbl, clk, prop)
`endif

`endif

// File: rtl/btot_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// btot_pkg
// Widths, types and helpers shared by the box/triangle overlap pipeline.
// ----------------------------------------------------------------------------
package btot_pkg;

    localparam int CW  = 20;          // packed coordinate width
    localparam int VW  = CW + 1;      // vertex relative to box center
    localparam int EW  = CW + 2;      // triangle edge
    localparam int XPW = VW + EW;     // product on an edge cross axis
    localparam int XSW = XPW + 2;     // sum on an edge cross axis
    localparam int NPW = 2 * EW;      // edge by edge product
    localparam int NW  = NPW + 1;     // normal component
    localparam int NMW = VW + NW;     // product on the normal axis
    localparam int NSW = NMW + 3;     // sum on the normal axis

    typedef logic signed [CW-1:0]  t_coord;
    typedef logic signed [VW-1:0]  t_vec;
    typedef logic signed [EW-1:0]  t_edge;
    typedef logic        [EW-1:0]  t_mag;
    typedef logic        [3*CW-1:0] t_packed;

    function automatic t_coord coord(input t_packed w, input logic [1:0] k);
        t_coord c;
        case (k)
            2'd0:    c = t_coord'(w[CW-1:0]);
            2'd1:    c = t_coord'(w[2*CW-1:CW]);
            2'd2:    c = t_coord'(w[3*CW-1:2*CW]);
            default: c = '0;
        endcase
        return c;
    endfunction

endpackage

// File: rtl/box_triangle_overlap_test_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// box_triangle_overlap_test_top
// Separating-axis overlap test of an axis-aligned box and a triangle.
// ----------------------------------------------------------------------------
// Usage:
// A request carries the box center, the box half extents and three triangle
// corners, each packed as x, y, z signed fixed-point values. It is taken on
// the input channel when i_valid and o_ready are both high. The response is
// a single bit, o_overlap, on the output channel, taken when o_valid and
// i_ready are both high. It is 1 when none of the 13 candidate axes
// separates the two shapes; touching counts as overlap.
// Throughput: one request per cycle. The pipeline is six stages plus an
// output register, and the widest step is the 21 by 45 bit product of the
// normal path, one multiplier per register stage.
// When the receiver stalls, the whole pipeline holds and o_ready drops; no
// request is lost or repeated. A new request is still taken in a stalled
// cycle if the output register is empty.
// Reset clears every valid bit; payload registers are not reset.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module box_triangle_overlap_test_top (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  btot_pkg::t_packed i_box_center,
    input  btot_pkg::t_packed i_half_extent,
    input  btot_pkg::t_packed i_vertex_a,
    input  btot_pkg::t_packed i_vertex_b,
    input  btot_pkg::t_packed i_vertex_c,
    output logic              o_valid,
    input  logic              i_ready,
    output logic              o_overlap
);

    // Stage valid bits, stage one in bit zero.
    logic [5:0]       r_vld;
    logic             r_ovld;
    logic             r_overlap;
    logic             w_en;

    btot_pkg::t_vec   w_v [3][3];
    btot_pkg::t_coord w_h [3];
    btot_pkg::t_edge  w_e [3][3];
    btot_pkg::t_mag   w_m [3][3];
    logic             w_box_ok;
    logic             w_x_ok;
    logic             w_n_ok;

    // Box-axis result is ready after stage two and the cross-axis result
    // after stage five; both are delayed to meet the normal test.
    logic [3:0]       r_box_d;
    logic             r_x_d;

    // Every stage advances together unless a response waits unaccepted.
    assign w_en    = !r_ovld || i_ready;
    assign o_ready = w_en;

    btot_prep u_prep (
        .i_clk         (i_clk),
        .i_en          (w_en),
        .i_box_center  (i_box_center),
        .i_half_extent (i_half_extent),
        .i_vertex_a    (i_vertex_a),
        .i_vertex_b    (i_vertex_b),
        .i_vertex_c    (i_vertex_c),
        .o_v           (w_v),
        .o_h           (w_h),
        .o_e           (w_e),
        .o_m           (w_m),
        .o_box_ok      (w_box_ok)
    );

    btot_xaxes u_xaxes (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_v   (w_v),
        .i_h   (w_h),
        .i_e   (w_e),
        .i_m   (w_m),
        .o_ok  (w_x_ok)
    );

    btot_normal u_normal (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_v0  (w_v[0]),
        .i_h   (w_h),
        .i_e0  (w_e[0]),
        .i_e1  (w_e[1]),
        .o_ok  (w_n_ok)
    );

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_box_d   <= {r_box_d[2:0], w_box_ok};
            r_x_d     <= w_x_ok;
            r_overlap <= r_box_d[3] && r_x_d && w_n_ok;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld  <= '0;
            r_ovld <= 1'b0;
        end else if (w_en) begin
            r_vld  <= {r_vld[4:0], i_valid};
            r_ovld <= r_vld[5];
        end
    end

    assign o_valid   = r_ovld;
    assign o_overlap = r_overlap;

    // A stalled response freezes every stage behind it.
    `BTOT_ASSERT(a_stall_freeze, i_clk, i_rst_n, (r_ovld && !i_ready) |=> $stable(r_vld))
    // A request enters stage one exactly when it is taken.
    `BTOT_ASSERT(a_entry, i_clk, i_rst_n, ($past(i_rst_n) && $past(o_ready)) |-> (r_vld[0] == $past(i_valid)))
    // A new response comes only from a valid last stage.
    `BTOT_ASSERT(a_out_src, i_clk, i_rst_n, $rose(o_valid) |-> $past(r_vld[5]))

endmodule

// File: rtl/btot_prep.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// btot_prep
// Stages one and two: vertices relative to the box center, edges, edge
// magnitudes and the three box-axis tests.
// ----------------------------------------------------------------------------
module btot_prep (
    input  logic               i_clk,
    input  logic               i_en,
    input  btot_pkg::t_packed  i_box_center,
    input  btot_pkg::t_packed  i_half_extent,
    input  btot_pkg::t_packed  i_vertex_a,
    input  btot_pkg::t_packed  i_vertex_b,
    input  btot_pkg::t_packed  i_vertex_c,
    output btot_pkg::t_vec     o_v [3][3],
    output btot_pkg::t_coord   o_h [3],
    output btot_pkg::t_edge    o_e [3][3],
    output btot_pkg::t_mag     o_m [3][3],
    output logic               o_box_ok
);

    btot_pkg::t_packed w_vtx [3];
    btot_pkg::t_vec    r_v1  [3][3];
    btot_pkg::t_coord  r_h1  [3];
    btot_pkg::t_vec    r_v2  [3][3];
    btot_pkg::t_coord  r_h2  [3];
    btot_pkg::t_edge   r_e   [3][3];
    btot_pkg::t_mag    r_m   [3][3];
    btot_pkg::t_edge   n_e   [3][3];
    logic [2:0]        w_ax_ok;
    logic              r_box_ok;

    assign w_vtx[0] = i_vertex_a;
    assign w_vtx[1] = i_vertex_b;
    assign w_vtx[2] = i_vertex_c;

    for (genvar gi = 0; gi < 3; gi++) begin : g_axis
        logic signed [btot_pkg::VW:0] w_lo [3];
        logic signed [btot_pkg::VW:0] w_hi [3];

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_h1[gi] <= btot_pkg::coord(i_half_extent, 2'(gi));
                r_h2[gi] <= r_h1[gi];
            end
        end

        // The box axis separates when all three corners lie beyond one face.
        for (genvar gk = 0; gk < 3; gk++) begin : g_vtx
            assign w_lo[gk] = (btot_pkg::VW+1)'(r_v1[gk][gi]) + (btot_pkg::VW+1)'(r_h1[gi]);
            assign w_hi[gk] = (btot_pkg::VW+1)'(r_v1[gk][gi]) - (btot_pkg::VW+1)'(r_h1[gi]);
        end
        assign w_ax_ok[gi] = !((w_hi[0] > 0 && w_hi[1] > 0 && w_hi[2] > 0) ||
                               (w_lo[0] < 0 && w_lo[1] < 0 && w_lo[2] < 0));

        for (genvar gk = 0; gk < 3; gk++) begin : g_edge
            localparam int NX = (gk + 1) % 3;

            assign n_e[gk][gi] = btot_pkg::t_edge'(r_v1[NX][gi]) -
                                 btot_pkg::t_edge'(r_v1[gk][gi]);

            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_v1[gk][gi] <=
                        btot_pkg::t_vec'(btot_pkg::coord(w_vtx[gk], 2'(gi))) -
                        btot_pkg::t_vec'(btot_pkg::coord(i_box_center, 2'(gi)));
                    r_v2[gk][gi] <= r_v1[gk][gi];
                    r_e[gk][gi]  <= n_e[gk][gi];
                    r_m[gk][gi]  <= n_e[gk][gi][btot_pkg::EW-1] ?
                                    btot_pkg::t_mag'(-n_e[gk][gi]) :
                                    btot_pkg::t_mag'(n_e[gk][gi]);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_box_ok <= &w_ax_ok;
        end
    end

    assign o_v      = r_v2;
    assign o_h      = r_h2;
    assign o_e      = r_e;
    assign o_m      = r_m;
    assign o_box_ok = r_box_ok;

endmodule

// File: rtl/btot_xaxes.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// btot_xaxes
// Stages three to five: the nine axes formed by a box axis crossed with a
// triangle edge. Products, then sums, then the interval tests.
// ----------------------------------------------------------------------------
module btot_xaxes (
    input  logic              i_clk,
    input  logic              i_en,
    input  btot_pkg::t_vec    i_v [3][3],
    input  btot_pkg::t_coord  i_h [3],
    input  btot_pkg::t_edge   i_e [3][3],
    input  btot_pkg::t_mag    i_m [3][3],
    output logic              o_ok
);

    typedef logic signed [btot_pkg::XPW-1:0] t_xp;
    typedef logic signed [btot_pkg::XSW-1:0] t_xs;

    logic [8:0] w_ok;
    logic       r_ok;

    // Both corners of the edge project to the same point, so only the edge
    // start and the opposite corner are projected.
    for (genvar gk = 0; gk < 3; gk++) begin : g_edge
        for (genvar gi = 0; gi < 3; gi++) begin : g_axis
            localparam int J  = (gi + 1) % 3;
            localparam int K  = (gi + 2) % 3;
            localparam int VA = gk;
            localparam int VB = (gk + 2) % 3;

            t_xp n_pa1, n_pa2, n_pb1, n_pb2, n_r1, n_r2;
            t_xp r_pa1, r_pa2, r_pb1, r_pb2, r_r1, r_r2;
            t_xs r_pa, r_pb, r_r;

            assign n_pa1 = i_v[VA][K] * i_e[gk][J];
            assign n_pa2 = i_v[VA][J] * i_e[gk][K];
            assign n_pb1 = i_v[VB][K] * i_e[gk][J];
            assign n_pb2 = i_v[VB][J] * i_e[gk][K];
            assign n_r1  = i_h[J] * $signed({1'b0, i_m[gk][K]});
            assign n_r2  = i_h[K] * $signed({1'b0, i_m[gk][J]});

            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_pa1 <= n_pa1;
                    r_pa2 <= n_pa2;
                    r_pb1 <= n_pb1;
                    r_pb2 <= n_pb2;
                    r_r1  <= n_r1;
                    r_r2  <= n_r2;
                    r_pa  <= t_xs'(r_pa1) - t_xs'(r_pa2);
                    r_pb  <= t_xs'(r_pb1) - t_xs'(r_pb2);
                    r_r   <= t_xs'(r_r1) + t_xs'(r_r2);
                end
            end

            assign w_ok[gk*3+gi] = !((r_pa > r_r && r_pb > r_r) ||
                                     (r_pa + r_r < 0 && r_pb + r_r < 0));
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ok <= &w_ok;
        end
    end

    assign o_ok = r_ok;

endmodule

// File: rtl/btot_normal.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// btot_normal
// Stages three to six: triangle normal, projection of the triangle plane and
// the box radius on it. The final compare is left to the output stage.
// ----------------------------------------------------------------------------
module btot_normal (
    input  logic              i_clk,
    input  logic              i_en,
    input  btot_pkg::t_vec    i_v0 [3],
    input  btot_pkg::t_coord  i_h  [3],
    input  btot_pkg::t_edge   i_e0 [3],
    input  btot_pkg::t_edge   i_e1 [3],
    output logic              o_ok
);

    typedef logic signed [btot_pkg::NPW-1:0] t_np;
    typedef logic signed [btot_pkg::NW-1:0]  t_n;
    typedef logic signed [btot_pkg::NMW-1:0] t_nm;
    typedef logic signed [btot_pkg::NSW-1:0] t_ns;

    t_np              r_c0 [3];
    t_np              r_c1 [3];
    t_n               r_n  [3];
    t_nm              r_p  [3];
    t_nm              r_q  [3];
    t_ns              w_rq [3];
    logic [2:0]       r_ns;
    btot_pkg::t_vec   r_v3 [3];
    btot_pkg::t_vec   r_v4 [3];
    btot_pkg::t_coord r_h3 [3];
    btot_pkg::t_coord r_h4 [3];
    t_ns              r_sp;
    t_ns              r_sr;

    for (genvar gi = 0; gi < 3; gi++) begin : g_comp
        localparam int J = (gi + 1) % 3;
        localparam int K = (gi + 2) % 3;

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_c0[gi] <= i_e0[J] * i_e1[K];
                r_c1[gi] <= i_e0[K] * i_e1[J];
                r_v3[gi] <= i_v0[gi];
                r_h3[gi] <= i_h[gi];
                r_n[gi]  <= t_n'(r_c0[gi]) - t_n'(r_c1[gi]);
                r_v4[gi] <= r_v3[gi];
                r_h4[gi] <= r_h3[gi];
                r_p[gi]  <= r_v4[gi] * r_n[gi];
                r_q[gi]  <= r_h4[gi] * r_n[gi];
                r_ns[gi] <= r_n[gi][btot_pkg::NW-1];
            end
        end

        // The radius uses the magnitude of each normal component.
        assign w_rq[gi] = r_ns[gi] ? -t_ns'(r_q[gi]) : t_ns'(r_q[gi]);
    end

    // All three corners lie in the plane, so one projection stands for all.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sp <= t_ns'(r_p[0]) + t_ns'(r_p[1]) + t_ns'(r_p[2]);
            r_sr <= w_rq[0] + w_rq[1] + w_rq[2];
        end
    end

    assign o_ok = !((r_sp > r_sr) || (r_sp + r_sr < 0));

endmodule

// File: verif/box_triangle_overlap_test_top_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// box_triangle_overlap_test_top_test
// Self-checking bench for the box/triangle separating-axis overlap test.
// Requests are driven with random idle cycles, the receiver stalls at random,
// and every response is compared in order against a predicted overlap bit.
// ----------------------------------------------------------------------------

// Holds the overlap bits predicted for accepted requests until they return.
class overlap_scoreboard;
    bit pending[$];
    int errors;
    int checked;
    int hits;

    // Signed coordinate k of a packed word, widened for exact arithmetic.
    static function longint unpack_axis(logic [59:0] w, int k);
        logic signed [19:0] c;
        c = w[k*20 +: 20];
        return longint'(c);
    endfunction

    // Exact dot product; 128 bits is ample for the widest normal products.
    static function logic signed [127:0] dot3(longint p[3], longint q[3]);
        logic signed [127:0] s;
        s = 0;
        for (int i = 0; i < 3; i++)
            s += 128'(signed'(p[i])) * 128'(signed'(q[i]));
        return s;
    endfunction

    // True when this axis does not separate the triangle from the box.
    static function bit axis_overlaps(longint v[3][3], longint ax[3], longint h[3]);
        logic signed [127:0] p, lo, hi, r;
        longint aa[3];
        for (int k = 0; k < 3; k++) begin
            p = dot3(v[k], ax);
            if (k == 0 || p < lo) lo = p;
            if (k == 0 || p > hi) hi = p;
        end
        for (int i = 0; i < 3; i++) aa[i] = ax[i] < 0 ? -ax[i] : ax[i];
        r = dot3(h, aa);
        return !(lo > r || -r > hi);
    endfunction

    static function void cross3(longint p[3], longint q[3], output longint o[3]);
        o[0] = p[1] * q[2] - p[2] * q[1];
        o[1] = p[2] * q[0] - p[0] * q[2];
        o[2] = p[0] * q[1] - p[1] * q[0];
    endfunction

    static function bit predict_overlap(logic [59:0] ctr, logic [59:0] hx,
                                        logic [59:0] va, logic [59:0] vb,
                                        logic [59:0] vc);
        longint v[3][3], e[3][3], h[3], ax[3], unitv[3], nrm[3];
        logic [59:0] corner[3];
        bit ok;
        ok = 1;
        corner[0] = va; corner[1] = vb; corner[2] = vc;
        for (int i = 0; i < 3; i++) begin
            h[i] = unpack_axis(hx, i);
            for (int k = 0; k < 3; k++)
                v[k][i] = unpack_axis(corner[k], i) - unpack_axis(ctr, i);
        end
        for (int i = 0; i < 3; i++) begin
            e[0][i] = v[1][i] - v[0][i];
            e[1][i] = v[2][i] - v[1][i];
            e[2][i] = v[0][i] - v[2][i];
        end
        for (int k = 0; k < 3; k++)
            for (int i = 0; i < 3; i++) begin
                unitv = '{0, 0, 0};
                unitv[i] = 1;
                cross3(unitv, e[k], ax);
                if (!axis_overlaps(v, ax, h)) ok = 0;
            end
        for (int i = 0; i < 3; i++) begin
            unitv = '{0, 0, 0};
            unitv[i] = 1;
            if (!axis_overlaps(v, unitv, h)) ok = 0;
        end
        cross3(e[0], e[1], nrm);
        if (!axis_overlaps(v, nrm, h)) ok = 0;
        return ok;
    endfunction

    function void note_request(logic [59:0] ctr, logic [59:0] hx, logic [59:0] va,
                               logic [59:0] vb, logic [59:0] vc);
        pending.insert(pending.size(), predict_overlap(ctr, hx, va, vb, vc));
    endfunction

    function void check_response(logic got);
        bit want;
        if (pending.size() == 0) begin
            $display("%0t: unexpected response, expected none, actual overlap=%b",
                     $time, got);
            errors++;
            return;
        end
        want = pending.pop_front();
        checked++;
        if (got) hits++;
        if (got !== want) begin
            $display("%0t: overlap mismatch, expected %b, actual %b", $time, want, got);
            errors++;
        end
    endfunction
endclass

module box_triangle_overlap_test_top_test;

    localparam int LATENCY    = 7;
    localparam int IDLE_LIMIT = 2000;
    localparam int N_RANDOM   = 1200;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_valid = 1'b0;
    logic              o_ready;
    btot_pkg::t_packed i_box_center = '0;
    btot_pkg::t_packed i_half_extent = '0;
    btot_pkg::t_packed i_vertex_a = '0;
    btot_pkg::t_packed i_vertex_b = '0;
    btot_pkg::t_packed i_vertex_c = '0;
    logic              o_valid;
    logic              i_ready = 1'b0;
    logic              o_overlap;

    overlap_scoreboard sb = new();
    int  idle_cycles = 0;
    bit  calm;           // when set, neither side idles
    bit  sink_enable;

    always #4 i_clk = ~i_clk;

    box_triangle_overlap_test_top dut (.*);

    // Response side: random stalls, checked at the edge where a response is taken.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) sb.check_response(o_overlap);
        if (i_rst_n && i_valid && o_ready)
            sb.note_request(i_box_center, i_half_extent, i_vertex_a, i_vertex_b,
                            i_vertex_c);
        i_ready <= sink_enable && (calm || $urandom_range(99) >= 30);
    end

    // Watchdog: counts cycles in which no request and no response is taken.
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready)) begin
            idle_cycles <= 0;
        end else if (i_rst_n) begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("Some tests failed");
                $finish;
            end
        end
    end

    function automatic btot_pkg::t_packed pack3(logic [19:0] x, logic [19:0] y,
                                                logic [19:0] z);
        return {z, y, x};
    endfunction

    // Sends one request, idling first at random, and holds it until it is taken.
    task automatic send_request(btot_pkg::t_packed c, btot_pkg::t_packed h,
                                btot_pkg::t_packed a, btot_pkg::t_packed b,
                                btot_pkg::t_packed v);
        while (!calm && $urandom_range(99) < 30) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid       <= 1'b1;
        i_box_center  <= c;
        i_half_extent <= h;
        i_vertex_a    <= a;
        i_vertex_b    <= b;
        i_vertex_c    <= v;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
    endtask

    function automatic logic [19:0] near_coord(int span);
        return 20'($signed($urandom_range(2 * span)) - span);
    endfunction

    // A box and triangle in the same neighborhood, so both answers are common.
    task automatic send_nearby(int span);
        int hs;
        hs = span / 2 + 1;
        send_request(pack3(near_coord(span), near_coord(span), near_coord(span)),
                     pack3(20'($urandom_range(hs)), 20'($urandom_range(hs)),
                           20'($urandom_range(hs))),
                     pack3(near_coord(span), near_coord(span), near_coord(span)),
                     pack3(near_coord(span), near_coord(span), near_coord(span)),
                     pack3(near_coord(span), near_coord(span), near_coord(span)));
    endtask

    // Waits one edge first so the last accepted request is already noted.
    task automatic drain();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 2) @(posedge i_clk);
    endtask

    initial begin
        btot_pkg::t_packed maxp, minp, t;
        int span;
        maxp = pack3(20'h7FFFF, 20'h7FFFF, 20'h7FFFF);
        minp = pack3(20'h80000, 20'h80000, 20'h80000);
        calm = 1'b0;
        sink_enable = 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        sink_enable = 1'b1;
        @(posedge i_clk);

        // Directed: coordinate extremes, touching faces, degenerate triangles,
        // negative half extents and clear separations.
        send_request(minp, maxp, maxp, minp, maxp);
        send_request(maxp, maxp, minp, minp, minp);
        send_request(minp, minp, maxp, maxp, minp);
        send_request('0, '0, '0, '0, '0);
        send_request('1, '1, '1, '1, '1);
        t = pack3(20'd256, 20'd256, 20'd256);
        // Triangle touches the +x face exactly.
        send_request('0, t, pack3(20'd256, 20'd0, 20'd0), pack3(20'd512, 20'd10, 20'd0),
                     pack3(20'd512, 20'd0, 20'd10));
        // One unit beyond the face.
        send_request('0, t, pack3(20'd257, 20'd0, 20'd0), pack3(20'd512, 20'd10, 20'd0),
                     pack3(20'd512, 20'd0, 20'd10));
        // Degenerate: two points, then a segment.
        send_request('0, t, pack3(20'd100, 20'd0, 20'd0), pack3(20'd100, 20'd0, 20'd0),
                     pack3(20'd100, 20'd0, 20'd0));
        send_request('0, t, pack3(20'd900, 20'd0, 20'd0), pack3(20'd900, 20'd0, 20'd0),
                     pack3(20'd900, 20'd0, 20'd0));
        send_request('0, t, pack3(-20'sd600, 20'd0, 20'd0), pack3(20'd600, 20'd0, 20'd0),
                     pack3(20'd0, 20'd0, 20'd0));
        // Negative half extent.
        send_request('0, pack3(-20'sd5, 20'd256, 20'd256), '0,
                     pack3(20'd10, 20'd0, 20'd0), pack3(20'd0, 20'd10, 20'd0));
        // Large triangle slicing through the box, then passing beside it.
        send_request('0, t, pack3(-20'sd9000, -20'sd9000, 20'd0),
                     pack3(20'd9000, -20'sd9000, 20'd0), pack3(20'd0, 20'd9000, 20'd0));
        send_request('0, t, pack3(-20'sd9000, -20'sd9000, 20'd300),
                     pack3(20'd9000, -20'sd9000, 20'd300), pack3(20'd0, 20'd9000, 20'd300));
        // Edge-cross axis separates: diagonal sliver near a corner.
        send_request('0, t, pack3(20'd520, 20'd0, 20'd10), pack3(20'd0, 20'd520, 20'd10),
                     pack3(20'd520, 20'd0, -20'sd10));
        drain();   // sender waits until every response has returned

        for (int n = 0; n < N_RANDOM; n++) begin
            calm = (n >= 400 && n < 550);
            span = ($urandom_range(9) == 0) ? 20'h7FFFF : ($urandom_range(1) ? 600 : 6000);
            if ($urandom_range(9) < 8)
                send_nearby(span);
            else
                send_request(60'({$urandom, $urandom}), 60'({$urandom, $urandom}),
                             60'({$urandom, $urandom}), 60'({$urandom, $urandom}),
                             60'({$urandom, $urandom}));
        end
        calm = 1'b0;
        drain();

        $display("Checked %0d overlap responses (%0d overlapping), directed and random.",
                 sb.checked, sb.hits);
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end
endmodule

// File: sim.f
+incdir+rtl
rtl/btot_pkg.sv
rtl/btot_prep.sv
rtl/btot_xaxes.sv
rtl/btot_normal.sv
rtl/box_triangle_overlap_test_top.sv
verif/box_triangle_overlap_test_top_test.sv
